FILE: rtl/crlp_pkg.sv
// Shared types, character codes and match-text tables for the CONNECT
// request line parser. No dependencies.
package crlp_pkg;

   // default bound on line length in bytes
   localparam int MAX_LINE_DEFAULT = 4096;

   // fixed field widths
   localparam int BYTE_W   = 8;
   localparam int PORT_W   = 16;
   localparam int ACC_W    = 17;
   localparam int HOST_W   = 12;

   // port accumulator saturation point and limits
   localparam logic [ACC_W-1:0]  PORT_SAT      = 17'd65536;
   localparam logic [ACC_W-1:0]  PORT_MAX      = 17'd65535;
   localparam logic [ACC_W-1:0]  PORT_MUL_LIM  = 17'd6553;
   localparam logic [HOST_W-1:0] HOST_MAX      = 12'd4095;

   // method text is "CONNECT " (eight bytes), so the authority starts here
   localparam int METHOD_LEN = 8;

   // version match indexes: done without CRLF, after CR, after CRLF
   localparam logic [3:0] VER_PREFIX_LEN = 4'd7;
   localparam logic [3:0] VER_DONE       = 4'd8;
   localparam logic [3:0] VER_CR         = 4'd9;
   localparam logic [3:0] VER_CRLF       = 4'd10;

   // character codes
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [BYTE_W-1:0] CH_ONE    = 8'h31;
   localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

   // one input word
   typedef struct packed {
      logic [BYTE_W-1:0] byte_req;
      logic              last;
   } req_type;

   // one result word
   typedef struct packed {
      logic              valid_res;
      logic [PORT_W-1:0] port;
      logic [HOST_W-1:0] host_offset;
      logic [HOST_W-1:0] host_length;
   } rsp_type;

   // expected method byte at a given match index
   function automatic logic [BYTE_W-1:0] method_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         3'd0:    ch = 8'h43; // C
         3'd1:    ch = 8'h4F; // O
         3'd2:    ch = 8'h4E; // N
         3'd3:    ch = 8'h4E; // N
         3'd4:    ch = 8'h45; // E
         3'd5:    ch = 8'h43; // C
         3'd6:    ch = 8'h54; // T
         default: ch = CH_SPACE;
      endcase
      return ch;
   endfunction

   // expected version prefix byte ("HTTP/1.") at a given match index
   function automatic logic [BYTE_W-1:0] version_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         3'd0:    ch = 8'h48; // H
         3'd1:    ch = 8'h54; // T
         3'd2:    ch = 8'h54; // T
         3'd3:    ch = 8'h50; // P
         3'd4:    ch = 8'h2F; // /
         3'd5:    ch = 8'h31; // 1
         default: ch = 8'h2E; // .
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/crlp_parser.sv
// Per-byte parse state and its next-state logic for the CONNECT line parser.
// Depends on crlp_pkg.
module crlp_parser #(
   parameter int MAX_LINE = crlp_pkg::MAX_LINE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  crlp_pkg::req_type word_in,
   output crlp_pkg::rsp_type result
);
   import crlp_pkg::*;

   localparam int LP_W = $clog2(MAX_LINE + 2);
   localparam logic [LP_W-1:0] LP_CAP   = LP_W'(MAX_LINE + 1);
   localparam logic [LP_W-1:0] LP_LIMIT = LP_W'(MAX_LINE);
   localparam logic [LP_W-1:0] LP_AUTH  = LP_W'(METHOD_LEN);

   typedef enum logic [1:0] {
      PH_METHOD,
      PH_AUTH,
      PH_VERSION
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [2:0]        method_idx_ff, method_idx_in;
   logic [LP_W-1:0]   line_pos_ff, line_pos_in;
   logic              bracketed_ff, bracketed_in;
   logic              bracket_closed_ff, bracket_closed_in;
   logic              colon_seen_ff, colon_seen_in;
   logic [ACC_W-1:0]  port_acc_ff, port_acc_in;
   logic              has_digit_ff, has_digit_in;
   logic [HOST_W-1:0] host_start_ff, host_start_in;
   logic [HOST_W-1:0] host_count_ff, host_count_in;
   logic [3:0]        version_idx_ff, version_idx_in;
   logic              failed_ff, failed_in;

   logic [BYTE_W-1:0] ch;
   logic              is_digit;
   logic [ACC_W-1:0]  acc_mul;

   assign ch       = word_in.byte_req;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   // acc * 10 + digit; the caller only uses it while acc <= 6553
   assign acc_mul  = ACC_W'(port_acc_ff << 3) + ACC_W'(port_acc_ff << 1)
                   + ACC_W'(ch[3:0]);

   // compute the updated state for the byte at the input
   always_comb begin
      logic host_step;
      logic port_step;
      logic ok;
      phase_in          = phase_ff;
      method_idx_in     = method_idx_ff;
      bracketed_in      = bracketed_ff;
      bracket_closed_in = bracket_closed_ff;
      colon_seen_in     = colon_seen_ff;
      port_acc_in       = port_acc_ff;
      has_digit_in      = has_digit_ff;
      host_start_in     = host_start_ff;
      host_count_in     = host_count_ff;
      version_idx_in    = version_idx_ff;
      failed_in         = failed_ff;
      host_step         = 1'b0;
      port_step         = 1'b0;

      // count bytes, stopping one past the bound
      line_pos_in = (line_pos_ff < LP_CAP) ? line_pos_ff + 1'b1 : line_pos_ff;
      if (line_pos_in > LP_LIMIT) begin
         failed_in = 1'b1;
      end

      if (!failed_in) begin
         case (phase_ff)
            PH_METHOD: begin
               if (ch == method_char(method_idx_ff)) begin
                  method_idx_in = method_idx_ff + 1'b1;
                  if (method_idx_ff == 3'd7) begin
                     phase_in = PH_AUTH;
                  end
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_AUTH: begin
               if (ch == CH_SPACE) begin
                  // close the authority: need host, colon and a port in range
                  if (!colon_seen_ff || !has_digit_ff || host_count_ff == '0 ||
                      port_acc_ff == '0 || port_acc_ff > PORT_MAX) begin
                     failed_in = 1'b1;
                  end else begin
                     phase_in = PH_VERSION;
                  end
               end else if (line_pos_ff == LP_AUTH && ch == CH_LBRACK) begin
                  bracketed_in  = 1'b1;
                  host_start_in = HOST_W'(METHOD_LEN + 1);
               end else begin
                  if (line_pos_ff == LP_AUTH) begin
                     host_start_in = HOST_W'(METHOD_LEN);
                  end
                  if (bracketed_ff) begin
                     if (!bracket_closed_ff) begin
                        if (ch == CH_RBRACK) begin
                           bracket_closed_in = 1'b1;
                        end else begin
                           host_step = 1'b1;
                        end
                     end else if (!colon_seen_ff) begin
                        if (ch == CH_COLON) begin
                           colon_seen_in = 1'b1;
                        end else begin
                           failed_in = 1'b1;
                        end
                     end else begin
                        port_step = 1'b1;
                     end
                  end else begin
                     if (ch == CH_COLON) begin
                        if (colon_seen_ff) begin
                           failed_in = 1'b1;
                        end else begin
                           colon_seen_in = 1'b1;
                        end
                     end else if (colon_seen_ff) begin
                        port_step = 1'b1;
                     end else begin
                        host_step = 1'b1;
                     end
                  end
               end
            end
            PH_VERSION: begin
               if (version_idx_ff < VER_PREFIX_LEN) begin
                  ok = (ch == version_char(version_idx_ff[2:0]));
               end else if (version_idx_ff == VER_PREFIX_LEN) begin
                  ok = (ch == CH_ZERO) || (ch == CH_ONE);
               end else if (version_idx_ff == VER_DONE) begin
                  ok = (ch == CH_CR);
               end else if (version_idx_ff == VER_CR) begin
                  ok = (ch == CH_LF);
               end else begin
                  ok = 1'b0;
               end
               if (ok) begin
                  version_idx_in = version_idx_ff + 1'b1;
               end else begin
                  failed_in = 1'b1;
               end
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase
      end

      // count a host character, failing past the host bound
      if (host_step) begin
         if (host_count_ff >= HOST_MAX) begin
            failed_in = 1'b1;
         end else begin
            host_count_in = host_count_ff + 1'b1;
         end
      end

      // accumulate a port digit with saturation
      if (port_step) begin
         if (!is_digit) begin
            failed_in = 1'b1;
         end else begin
            has_digit_in = 1'b1;
            if (port_acc_ff > PORT_MUL_LIM || acc_mul > PORT_SAT) begin
               port_acc_in = PORT_SAT;
            end else begin
               port_acc_in = acc_mul;
            end
         end
      end

      // form the result from the updated state
      ok = !failed_in && phase_in == PH_VERSION &&
           (version_idx_in == VER_DONE || version_idx_in == VER_CRLF);
      result.valid_res   = ok;
      result.port        = ok ? port_acc_in[PORT_W-1:0] : '0;
      result.host_offset = ok ? host_start_in : '0;
      result.host_length = ok ? host_count_in : '0;
   end

   // hold state; advance on each byte and clear after the last one
   always_ff @(posedge clock) begin
      if (reset || (step && word_in.last)) begin
         phase_ff          <= PH_METHOD;
         method_idx_ff     <= '0;
         line_pos_ff       <= '0;
         bracketed_ff      <= 1'b0;
         bracket_closed_ff <= 1'b0;
         colon_seen_ff     <= 1'b0;
         port_acc_ff       <= '0;
         has_digit_ff      <= 1'b0;
         host_start_ff     <= '0;
         host_count_ff     <= '0;
         version_idx_ff    <= '0;
         failed_ff         <= 1'b0;
      end else if (step) begin
         phase_ff          <= phase_in;
         method_idx_ff     <= method_idx_in;
         line_pos_ff       <= line_pos_in;
         bracketed_ff      <= bracketed_in;
         bracket_closed_ff <= bracket_closed_in;
         colon_seen_ff     <= colon_seen_in;
         port_acc_ff       <= port_acc_in;
         has_digit_ff      <= has_digit_in;
         host_start_ff     <= host_start_in;
         host_count_ff     <= host_count_in;
         version_idx_ff    <= version_idx_in;
         failed_ff         <= failed_in;
      end
   end

endmodule

FILE: rtl/connect_request_line_parser_unit.sv
// Top level of the CONNECT request line parser: input register, parser
// state, result register. Depends on crlp_pkg and crlp_parser.
// A result is loaded into the result register when the parser takes its last byte.
// Throughput: one byte per cycle; a last byte waits in the input register
// only while the result register still holds an untaken result.
// Reset: synchronous, active high; clears the valid flags and parse state.
module connect_request_line_parser_unit #(
   parameter int MAX_LINE = crlp_pkg::MAX_LINE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  crlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output crlp_pkg::rsp_type rsp_data
);
   import crlp_pkg::*;

   logic    in_valid_ff;
   req_type in_word_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_word_ff;
   rsp_type result;
   logic    out_free;
   logic    in_go;

   // a byte without last never needs the result register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_go     = in_valid_ff && (!in_word_ff.last || out_free);
   assign req_stall = in_valid_ff && !in_go;

   crlp_parser #(
      .MAX_LINE (MAX_LINE)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (in_go),
      .word_in (in_word_ff),
      .result  (result)
   );

   // hold the input word until the parser takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (in_go) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_word_ff <= req_data;
      end
   end

   // load a result on the last byte, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_go && in_word_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (in_go && in_word_ff.last) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule
